FILE: hdl/prst_pkg.sv
// ----------------------------------------------------------------------------
// prst_pkg: shared types and constants of the peer reputation score table
// Request and result layouts, event modes, config indexes and score limits.
// ----------------------------------------------------------------------------
`default_nettype none

package prst_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned SCORE_W = 14;
    localparam int unsigned DELTA_W = 16;

    localparam logic [SCORE_W-1:0]        SCORE_MAX   = 14'd10000;
    localparam logic signed [DELTA_W-1:0] SCORE_MAX_S = 16'sd10000;
    localparam logic signed [DELTA_W-1:0] SCORE_MIN_S = -16'sd10000;

    typedef enum logic [2:0] {
        MODE_FLOOD     = 3'd0,
        MODE_REPLAY    = 3'd1,
        MODE_SIGNATURE = 3'd2,
        MODE_CUSTODY   = 3'd3,
        MODE_SUCCESS   = 3'd4,
        MODE_FAILURE   = 3'd5,
        MODE_WEIGHTED  = 3'd6,
        MODE_QUERY     = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        CFG_FLOOD     = 3'd0,
        CFG_REPLAY    = 3'd1,
        CFG_SIGNATURE = 3'd2,
        CFG_CUSTODY   = 3'd3,
        CFG_FAILURE   = 3'd4,
        CFG_SUCCESS   = 3'd5,
        CFG_DEFAULT   = 3'd6,
        CFG_UNUSED    = 3'd7
    } t_cfg_idx;

    localparam logic [SCORE_W-1:0] RST_FLOOD     = 14'd500;
    localparam logic [SCORE_W-1:0] RST_REPLAY    = 14'd1500;
    localparam logic [SCORE_W-1:0] RST_SIGNATURE = 14'd2000;
    localparam logic [SCORE_W-1:0] RST_CUSTODY   = 14'd500;
    localparam logic [SCORE_W-1:0] RST_FAILURE   = 14'd200;
    localparam logic [SCORE_W-1:0] RST_SUCCESS   = 14'd100;
    localparam logic [SCORE_W-1:0] RST_DEFAULT   = 14'd10000;

    typedef struct packed {
        t_mode                     mode;
        logic [KEY_W-1:0]          peer_key;
        logic signed [DELTA_W-1:0] adj_delta;
    } t_req;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               was_known;
        logic               evicted;
    } t_rsp;

    // Classified request passed from front to back.
    typedef struct packed {
        t_mode                     mode;
        logic [KEY_W-1:0]          peer_key;
        logic signed [DELTA_W-1:0] delta;
    } t_job;

    typedef struct packed {
        logic [SCORE_W-1:0] flood;
        logic [SCORE_W-1:0] replay;
        logic [SCORE_W-1:0] signature;
        logic [SCORE_W-1:0] custody;
        logic [SCORE_W-1:0] failure;
        logic [SCORE_W-1:0] success;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_APPLY = 2'd2
    } t_bk_state;

endpackage

`default_nettype wire

FILE: hdl/prst_queue.sv
// ----------------------------------------------------------------------------
// prst_queue: two-entry job queue
// Decouples the classifying front from the table-walking back.
// ----------------------------------------------------------------------------
`default_nettype none

module prst_queue
    import prst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_data,
    output logic      o_full,
    output logic      o_vld,
    output t_job      o_data,
    input  wire logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_vld |-> !i_pop) else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: hdl/prst_front.sv
// ----------------------------------------------------------------------------
// prst_front: request intake and classification
// Turns the mode into a signed score delta and pushes the job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module prst_front
    import prst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_vld,
    input  wire t_req i_req,
    output logic      o_stall,
    input  wire t_cfg i_cfg,
    output logic      o_job_vld,
    output t_job      o_job,
    input  wire logic i_job_pop
);

    logic                      full;
    logic                      push;
    logic signed [DELTA_W-1:0] delta;
    t_job                      job;

    // Penalties subtract, the reward adds, weighted deltas clamp to +-1.0.
    always_comb begin
        unique case (i_req.mode)
            MODE_FLOOD:     delta = -signed'({2'b00, i_cfg.flood});
            MODE_REPLAY:    delta = -signed'({2'b00, i_cfg.replay});
            MODE_SIGNATURE: delta = -signed'({2'b00, i_cfg.signature});
            MODE_CUSTODY:   delta = -signed'({2'b00, i_cfg.custody});
            MODE_SUCCESS:   delta = signed'({2'b00, i_cfg.success});
            MODE_FAILURE:   delta = -signed'({2'b00, i_cfg.failure});
            default: begin
                if (i_req.adj_delta > SCORE_MAX_S) begin
                    delta = SCORE_MAX_S;
                end else if (i_req.adj_delta < SCORE_MIN_S) begin
                    delta = SCORE_MIN_S;
                end else begin
                    delta = i_req.adj_delta;
                end
            end
        endcase
        job.mode     = i_req.mode;
        job.peer_key = i_req.peer_key;
        job.delta    = delta;
    end

    assign o_stall = full;
    assign push    = i_vld && !full;

    prst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job),
        .o_full  (full),
        .o_vld   (o_job_vld),
        .o_data  (o_job),
        .i_pop   (i_job_pop)
    );

endmodule

`default_nettype wire

FILE: hdl/prst_back.sv
// ----------------------------------------------------------------------------
// prst_back: table walk and score update
// Scans stored keys one per cycle, then inserts or updates (a query only reads) and emits a result.
// ----------------------------------------------------------------------------
`default_nettype none

module prst_back
    import prst_pkg::*;
#(
    parameter int unsigned ENTRIES  = 64,
    parameter int unsigned KEY_BITS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_vld,
    input  wire t_job               i_job,
    output logic                    o_job_pop,
    input  wire logic [SCORE_W-1:0] i_dflt,
    output logic                    o_vld,
    output t_rsp                    o_rsp,
    input  wire logic               i_stall
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [KEY_BITS-1:0] r_key_mem   [ENTRIES];
    logic [SCORE_W-1:0]  r_score_mem [ENTRIES];

    t_bk_state           r_state, n_state;
    t_job                r_job;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_oldest;
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [KEY_BITS-1:0] r_key_q;
    logic [SCORE_W-1:0]  r_score_q;
    logic                r_hit;
    logic [IDX_W-1:0]    r_slot;
    logic [SCORE_W-1:0]  r_base;
    logic                r_out_vld;
    t_rsp                r_out;

    logic                      rd_en;
    logic                      hit;
    logic                      scan_done;
    logic                      out_free;
    logic                      fire;
    logic                      is_query;
    logic                      full;
    logic [KEY_BITS-1:0]       job_key;
    logic [SCORE_W-1:0]        base;
    logic [IDX_W-1:0]          wr_slot;
    logic signed [DELTA_W-1:0] sum;
    logic [SCORE_W-1:0]        new_score;

    assign job_key   = r_job.peer_key[KEY_BITS-1:0];
    assign full      = (r_count == FULL_CNT);
    assign rd_en     = (r_state == ST_SCAN) && (r_rd_idx < r_count);
    assign hit       = (r_state == ST_SCAN) && r_cmp_vld && (r_key_q == job_key);
    assign scan_done = !rd_en && !r_cmp_vld;
    assign out_free  = !r_out_vld || !i_stall;
    assign fire      = (r_state == ST_APPLY) && out_free;
    assign is_query  = (r_job.mode == MODE_QUERY);
    assign base      = r_hit ? r_base : i_dflt;
    assign wr_slot   = r_hit ? r_slot : (full ? r_oldest : r_count[IDX_W-1:0]);
    assign sum       = signed'({2'b00, base}) + r_job.delta;

    always_comb begin
        if (sum < 0) begin
            new_score = '0;
        end else if (sum > SCORE_MAX_S) begin
            new_score = SCORE_MAX;
        end else begin
            new_score = sum[SCORE_W-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_vld) begin
                    o_job_pop = 1'b1;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || scan_done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Table storage: one registered read port, one write port.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_key_q   <= r_key_mem[r_rd_idx[IDX_W-1:0]];
            r_score_q <= r_score_mem[r_rd_idx[IDX_W-1:0]];
        end
        if (fire && !is_query) begin
            r_key_mem[wr_slot]   <= job_key;
            r_score_mem[wr_slot] <= new_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == ST_SCAN) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
            if (hit) begin
                r_slot <= r_cmp_idx;
                r_base <= r_score_q;
            end
        end
        if (fire) begin
            r_out.score     <= is_query ? base : new_score;
            r_out.was_known <= r_hit;
            r_out.evicted   <= !is_query && !r_hit && full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_oldest  <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_job_pop) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_cmp_vld <= rd_en && !hit;
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (fire && !is_query && !r_hit) begin
                if (full) begin
                    r_oldest <= (r_oldest == LAST_IDX) ? '0 : r_oldest + 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_vld = r_out_vld;
    assign o_rsp = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT) else $error("entry count above table size");
    a_oldest_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> full) else $error("eviction pointer moved before full");
    a_evict_not_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.evicted && r_out.was_known))
        else $error("eviction reported for a known peer");
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.score <= SCORE_MAX)) else $error("score out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == ST_SCAN)) else $error("pop without scan start");
`endif

endmodule

`default_nettype wire

FILE: hdl/peer_reputation_score_table_unit.sv
// Flow: the back scans the stored keys one per cycle and stops at a hit, so a
//   request takes longer as the table fills. New requests are still accepted
//   while the back is busy, until the queue is full: up to two requests
//   wait in the queue and one finished result waits in the output register.
// Reset: synchronous, active low; empties the table and queue and reloads the
//   config registers with their defaults. Table contents need no clearing.
// ----------------------------------------------------------------------------
// peer_reputation_score_table_unit: peer reputation score table
// Config registers, classifying front, job queue and table-walking back.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_reputation_score_table_unit
    import prst_pkg::*;
#(
    parameter int unsigned ENTRIES  = 64,
    parameter int unsigned KEY_BITS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_vld,
    input  wire t_req               i_req,
    output logic                    o_stall,
    // result channel
    output logic                    o_vld,
    output t_rsp                    o_rsp,
    input  wire logic               i_stall,
    // config write port
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [SCORE_W-1:0] i_cfg_wdata
);

    t_cfg               r_cfg;
    logic [SCORE_W-1:0] r_dflt_raw;
    logic [SCORE_W-1:0] dflt;
    logic               job_vld;
    t_job               job;
    logic               job_pop;

    // Hold config; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flood     <= RST_FLOOD;
            r_cfg.replay    <= RST_REPLAY;
            r_cfg.signature <= RST_SIGNATURE;
            r_cfg.custody   <= RST_CUSTODY;
            r_cfg.failure   <= RST_FAILURE;
            r_cfg.success   <= RST_SUCCESS;
            r_dflt_raw      <= RST_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FLOOD:     r_cfg.flood     <= i_cfg_wdata;
                CFG_REPLAY:    r_cfg.replay    <= i_cfg_wdata;
                CFG_SIGNATURE: r_cfg.signature <= i_cfg_wdata;
                CFG_CUSTODY:   r_cfg.custody   <= i_cfg_wdata;
                CFG_FAILURE:   r_cfg.failure   <= i_cfg_wdata;
                CFG_SUCCESS:   r_cfg.success   <= i_cfg_wdata;
                CFG_DEFAULT:   r_dflt_raw      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the default score to 1.0 for inserts and unknown-peer queries.
    assign dflt = (r_dflt_raw > SCORE_MAX) ? SCORE_MAX : r_dflt_raw;

    prst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_vld),
        .i_req     (i_req),
        .o_stall   (o_stall),
        .i_cfg     (r_cfg),
        .o_job_vld (job_vld),
        .o_job     (job),
        .i_job_pop (job_pop)
    );

    prst_back #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (job_vld),
        .i_job     (job),
        .o_job_pop (job_pop),
        .i_dflt    (dflt),
        .o_vld     (o_vld),
        .o_rsp     (o_rsp),
        .i_stall   (i_stall)
    );

`ifndef ASSERT_OFF
    a_dflt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dflt <= SCORE_MAX) else $error("default score out of range");
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_vld) else $error("back popped an empty queue");
    a_reset_dflt: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_dflt_raw == RST_DEFAULT)) else $error("default not reloaded");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_peer_reputation_score_table_unit.sv
// ----------------------------------------------------------------------------
// tb_peer_reputation_score_table_unit: self-checking bench of the score table
// Drives directed and random requests with random gaps on both channels,
// predicts each result with a behavioral copy of the table, and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_peer_reputation_score_table_unit;
    import prst_pkg::*;

    localparam int ENTRIES   = 64;
    localparam int N_RANDOM  = 560;
    localparam int CYC_LIMIT = 400000;
    localparam int SETTLE    = ENTRIES + 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_vld = 1'b0;
    t_req              i_req = '0;
    logic              o_stall;
    logic              o_vld;
    t_rsp              o_rsp;
    logic              i_stall = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_idx = '0;
    logic [SCORE_W-1:0] i_cfg_wdata = '0;

    peer_reputation_score_table_unit #(.ENTRIES(ENTRIES), .KEY_BITS(64)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(i_vld), .i_req(i_req), .o_stall(o_stall),
        .o_vld(o_vld), .o_rsp(o_rsp), .i_stall(i_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow table and registers of the predictor
    logic [KEY_W-1:0]   tbl_key [ENTRIES];
    logic [SCORE_W-1:0] tbl_score [ENTRIES];
    int                 tbl_count;
    int                 tbl_oldest;
    logic [SCORE_W-1:0] shadow_reg [8];

    t_rsp score_queue[$];
    int   errors = 0;
    int   cycles = 0;
    bit   hold_off = 1'b0;
    bit   long_hold_req = 1'b0;

    // Known peers for revisits, so that lookups hit as well as miss
    logic [KEY_W-1:0] key_pool[$];

    function automatic logic [SCORE_W-1:0] default_score_now();
        return (shadow_reg[CFG_DEFAULT] > SCORE_MAX) ? SCORE_MAX : shadow_reg[CFG_DEFAULT];
    endfunction

    function automatic t_rsp score_update(t_req rq);
        t_rsp r;
        int   slot;
        int   delta;
        int   s;
        slot = -1;
        for (int i = 0; i < tbl_count; i++)
            if (slot < 0 && tbl_key[i] == rq.peer_key) slot = i;
        r = '0;
        r.was_known = (slot >= 0);
        if (rq.mode == MODE_QUERY) begin
            r.score = r.was_known ? tbl_score[slot] : default_score_now();
            return r;
        end
        if (slot < 0) begin
            if (tbl_count < ENTRIES) begin
                slot = tbl_count;
                tbl_count++;
            end else begin
                slot = tbl_oldest;
                tbl_oldest = (tbl_oldest + 1) % ENTRIES;
                r.evicted = 1'b1;
            end
            tbl_key[slot] = rq.peer_key;
            tbl_score[slot] = default_score_now();
        end
        case (rq.mode)
            MODE_FLOOD:     delta = -int'(shadow_reg[CFG_FLOOD]);
            MODE_REPLAY:    delta = -int'(shadow_reg[CFG_REPLAY]);
            MODE_SIGNATURE: delta = -int'(shadow_reg[CFG_SIGNATURE]);
            MODE_CUSTODY:   delta = -int'(shadow_reg[CFG_CUSTODY]);
            MODE_SUCCESS:   delta = int'(shadow_reg[CFG_SUCCESS]);
            MODE_FAILURE:   delta = -int'(shadow_reg[CFG_FAILURE]);
            default: begin
                delta = int'(rq.adj_delta);
                if (delta > 10000) delta = 10000;
                if (delta < -10000) delta = -10000;
            end
        endcase
        s = int'(tbl_score[slot]) + delta;
        if (s < 0) s = 0;
        if (s > 10000) s = 10000;
        tbl_score[slot] = s[SCORE_W-1:0];
        r.score = s[SCORE_W-1:0];
        return r;
    endfunction

    // Write one register; only called while the block is idle
    task automatic cfg_write(t_cfg_idx idx, logic [SCORE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        if (idx != CFG_UNUSED) shadow_reg[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one request and hold it until accepted; predict at acceptance.
    // Valid stays high on return so the next request can follow back to back.
    task automatic send_request(t_req rq, bit allow_gap);
        int gap;
        if (allow_gap) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
                  (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
            if (gap != 0) begin
                i_vld <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_vld <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (o_stall);
        score_queue.push_back(score_update(rq));
    endtask

    task automatic drain();
        i_vld <= 1'b0;
        while (score_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 60)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = {$urandom, $urandom};
        // keep a bounded pool so misses keep forcing evictions
        if (key_pool.size() < 90) key_pool.push_back(k);
        else key_pool[$urandom_range(0, key_pool.size() - 1)] = k;
        return k;
    endfunction

    function automatic t_req random_request();
        t_req rq;
        rq.mode = t_mode'($urandom_range(0, 7));
        rq.peer_key = pick_key();
        case ($urandom_range(0, 3))
            0:       rq.adj_delta = 16'sh8000 + 16'($urandom_range(0, 30000));
            1:       rq.adj_delta = 16'($urandom_range(0, 20000));
            default: rq.adj_delta = 16'($urandom);
        endcase
        return rq;
    endfunction

    // Result side: random stall, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && hold_off) begin
            i_stall <= 1'b1;
        end else if (i_rst_n) begin
            i_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
        end
    end

    initial begin
        wait (long_hold_req);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_vld && !i_stall) begin
            if (score_queue.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, o_rsp);
                errors++;
            end else begin
                t_rsp want;
                want = score_queue.pop_front();
                if (o_rsp.score !== want.score) begin
                    $display("%0t: score expected %0d actual %0d", $time, want.score, o_rsp.score);
                    errors++;
                end
                if (o_rsp.was_known !== want.was_known) begin
                    $display("%0t: was_known expected %0b actual %0b",
                             $time, want.was_known, o_rsp.was_known);
                    errors++;
                end
                if (o_rsp.evicted !== want.evicted) begin
                    $display("%0t: evicted expected %0b actual %0b",
                             $time, want.evicted, o_rsp.evicted);
                    errors++;
                end
            end
        end
        if (cycles >= CYC_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    typedef struct {
        t_mode            mode;
        logic [KEY_W-1:0] key;
        logic [15:0]      wd;
        bit               typed;
        t_rsp             want;
    } t_row;

    t_row directed [$];

    task automatic run_directed();
        t_rsp got;
        foreach (directed[i]) begin
            t_req rq;
            rq.mode = directed[i].mode;
            rq.peer_key = directed[i].key;
            rq.adj_delta = directed[i].wd;
            send_request(rq, 1'b0);
            got = score_queue[$];
            if (directed[i].typed && got !== directed[i].want) begin
                $display("%0t: directed row %0d expected %p actual %p",
                         $time, i, directed[i].want, got);
                errors++;
            end
        end
    endtask

    function automatic void add_row(t_mode m, logic [KEY_W-1:0] k, logic [15:0] w,
                                    bit typed, int sc, bit kn, bit ev);
        t_row r;
        r.mode = m; r.key = k; r.wd = w; r.typed = typed;
        r.want.score = 14'(sc); r.want.was_known = kn; r.want.evicted = ev;
        directed.push_back(r);
    endfunction

    initial begin
        shadow_reg[CFG_FLOOD]     = RST_FLOOD;
        shadow_reg[CFG_REPLAY]    = RST_REPLAY;
        shadow_reg[CFG_SIGNATURE] = RST_SIGNATURE;
        shadow_reg[CFG_CUSTODY]   = RST_CUSTODY;
        shadow_reg[CFG_FAILURE]   = RST_FAILURE;
        shadow_reg[CFG_SUCCESS]   = RST_SUCCESS;
        shadow_reg[CFG_DEFAULT]   = RST_DEFAULT;
        tbl_count = 0;
        tbl_oldest = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults, every mode, key extremes, weighted saturation
        add_row(MODE_QUERY,     64'h0, 16'h0, 1, 10000, 0, 0);
        add_row(MODE_FLOOD,     64'h0, 16'h0, 1, 9500, 0, 0);
        add_row(MODE_REPLAY,    64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1, 8500, 0, 0);
        add_row(MODE_SIGNATURE, 64'h0, 16'h0, 1, 7500, 1, 0);
        add_row(MODE_CUSTODY,   64'h0, 16'h0, 1, 7000, 1, 0);
        add_row(MODE_FAILURE,   64'h0, 16'h0, 1, 6800, 1, 0);
        add_row(MODE_SUCCESS,   64'h0, 16'h0, 1, 6900, 1, 0);
        add_row(MODE_WEIGHTED,  64'h0, 16'h8000, 1, 0, 1, 0);
        add_row(MODE_WEIGHTED,  64'h0, 16'h7FFF, 1, 10000, 1, 0);
        add_row(MODE_WEIGHTED,  64'h0, 16'hD8F0, 1, 0, 1, 0);
        add_row(MODE_WEIGHTED,  64'h0, 16'h2710, 1, 10000, 1, 0);
        add_row(MODE_WEIGHTED,  64'h5555_AAAA_5555_AAAA, 16'hFFFF, 1, 9999, 0, 0);
        add_row(MODE_QUERY,     64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1, 8500, 1, 0);
        add_row(MODE_QUERY,     64'h8000_0000_0000_0001, 16'hFFFF, 1, 10000, 0, 0);
        add_row(MODE_SUCCESS,   64'hAAAA_5555_AAAA_5555, 16'h0, 1, 10000, 0, 0);
        run_directed();
        drain();

        // Penalty and default extremes, including out-of-range values and a bad index
        cfg_write(CFG_DEFAULT, 14'h3FFF);
        cfg_write(CFG_FLOOD, 14'h3FFF);
        cfg_write(CFG_SUCCESS, 14'h3FFF);
        cfg_write(CFG_UNUSED, 14'h1234);
        directed.delete();
        add_row(MODE_QUERY,   64'h1234, 16'h0, 1, 10000, 0, 0);
        add_row(MODE_FLOOD,   64'h1234, 16'h0, 1, 0, 0, 0);
        add_row(MODE_SUCCESS, 64'h1234, 16'h0, 1, 10000, 1, 0);
        run_directed();
        drain();

        // Fill past capacity so eviction wraps all the way around
        cfg_write(CFG_DEFAULT, 14'd0);
        cfg_write(CFG_REPLAY, 14'd0);
        cfg_write(CFG_SIGNATURE, 14'd10000);
        cfg_write(CFG_CUSTODY, 14'd1);
        cfg_write(CFG_FAILURE, 14'd9999);
        for (int i = 0; i < 2 * ENTRIES + 5; i++) begin
            t_req rq;
            rq = random_request();
            rq.peer_key = {$urandom, $urandom};
            if (rq.mode == MODE_QUERY) rq.mode = MODE_SUCCESS;
            send_request(rq, 1'b1);
        end

        // Long receiver hold-off while requests keep coming, then a full pause
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_request(random_request(), 1'b0);
        drain();

        // Random phases at several register settings
        for (int ph = 0; ph < 4; ph++) begin
            for (int r = CFG_FLOOD; r <= CFG_DEFAULT; r++)
                cfg_write(t_cfg_idx'(r), (ph == 3) ? 14'h3FFF :
                          ((ph == 0) ? 14'd0 : 14'($urandom_range(0, 12000))));
            for (int i = 0; i < N_RANDOM / 4; i++) send_request(random_request(), 1'b1);
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/prst_pkg.sv
hdl/prst_queue.sv
hdl/prst_front.sv
hdl/prst_back.sv
hdl/peer_reputation_score_table_unit.sv
sim/tb_peer_reputation_score_table_unit.sv
